// ===== rtl/rqr_pkg.sv =====
// shared constants for the ring queue with in-place reverse
`default_nettype none
package rqr_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int ACTION_W      = 2;
   localparam int FILL_W        = 5;

   // request codes
   localparam logic [ACTION_W-1:0] ACT_ENQ = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQ = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REV = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/rqr_wrap.sv =====
// shared modular index adder: (base + offset) mod DEPTH
`default_nettype none
module rqr_wrap #(
   parameter int DEPTH = rqr_pkg::DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire logic [IDX_W-1:0] base,
   input  wire logic [IDX_W-1:0] offset,
   output logic      [IDX_W-1:0] index
);

   localparam logic [IDX_W:0] WRAP = (IDX_W + 1)'(DEPTH);

   logic [IDX_W:0] sum;
   logic [IDX_W:0] folded;

   // both operands stay below DEPTH, so one subtract is enough
   always_comb begin
      sum    = {1'b0, base} + {1'b0, offset};
      folded = (sum >= WRAP) ? (sum - WRAP) : sum;
      index  = folded[IDX_W-1:0];
   end

endmodule
`default_nettype wire

// ===== rtl/ring_queue_with_reverse_core.sv =====
// top level of the ring queue with in-place reverse
`default_nettype none
// Circular FIFO of DEPTH signed 32-bit words held in a one-read, one-write
// memory. Each request transfer returns exactly one response transfer carrying
// status, dequeued word and the occupancy after the request. Enqueue, an
// unused request code and a reverse of fewer than two entries load the response
// register in the cycle that accepts them; a dequeue answers from ST_DEQ_DATA
// because the memory read data is registered. A reverse of n entries spends its
// accept cycle setting up, then walks floor(n/2) swaps, each stepping through
// read low, read high, write low and write high, all addresses coming from one
// shared modular adder. The response sits in an output register and the next
// request is taken once it has been transferred, so a new request is never
// accepted while a response is still owed. Memory contents are not cleared at
// reset; only stored entries are ever read.
module ring_queue_with_reverse_core #(
   parameter int DEPTH = rqr_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [rqr_pkg::ACTION_W-1:0]     req_action,
   input  wire logic signed [rqr_pkg::DATA_W-1:0] req_push_value,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_ok,
   output logic signed [rqr_pkg::DATA_W-1:0]     rsp_pop_value,
   output logic                                  rsp_is_empty,
   output logic                                  rsp_is_full,
   output logic [rqr_pkg::FILL_W-1:0]            rsp_fill_count
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = rqr_pkg::DATA_W;
   localparam int FILL_W = rqr_pkg::FILL_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DEQ_DATA  = 3'd1;
   localparam logic [2:0] ST_REV_RD_LO = 3'd2;
   localparam logic [2:0] ST_REV_RD_HI = 3'd3;
   localparam logic [2:0] ST_REV_WR_LO = 3'd4;
   localparam logic [2:0] ST_REV_WR_HI = 3'd5;

   // control state
   logic [2:0]       state_ff,  state_in;
   logic [IDX_W-1:0] head_ff,   head_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [IDX_W-1:0] lo_ff,     lo_in;
   logic [IDX_W-1:0] hi_ff,     hi_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [IDX_W-1:0]  addr_lo_ff, addr_lo_in;
   logic [IDX_W-1:0]  addr_hi_ff, addr_hi_in;
   logic [DATA_W-1:0] hold_ff,    hold_in;
   logic              rsp_ok_ff,  rsp_ok_in;
   logic [DATA_W-1:0] rsp_pop_ff, rsp_pop_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_full_ff,  rsp_full_in;
   logic [FILL_W-1:0] rsp_fill_ff,  rsp_fill_in;
   logic              rsp_load;

   // slot memory
   logic [DATA_W-1:0] slots [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;

   // shared address unit
   logic [IDX_W-1:0] wrap_offset;
   logic [IDX_W-1:0] wrap_index;

   logic             req_fire;
   logic [CNT_W-1:0] count_m1;
   logic [IDX_W:0]   lo_plus2;
   logic [FILL_W+CNT_W-1:0] fill_ext;

   rqr_wrap #(
      .DEPTH (DEPTH)
   ) u_wrap (
      .base   (head_ff),
      .offset (wrap_offset),
      .index  (wrap_index)
   );

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign count_m1  = count_ff - CNT_W'(1);
   assign lo_plus2  = {1'b0, lo_ff} + (IDX_W + 1)'(2);

   // sequencer and datapath steering
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      addr_lo_in   = addr_lo_ff;
      addr_hi_in   = addr_hi_ff;
      hold_in      = hold_ff;
      rsp_load     = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_pop_in   = '0;
      wrap_offset  = lo_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = head_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = addr_lo_ff;
      mem_wr_data  = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  rqr_pkg::ACT_ENQ: begin
                     // tail slot is head + count
                     wrap_offset = count_ff[IDX_W-1:0];
                     rsp_load    = 1'b1;
                     if (count_ff != CNT_FULL) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = wrap_index;
                        mem_wr_data = req_push_value;
                        count_in    = count_ff + CNT_W'(1);
                        rsp_ok_in   = 1'b1;
                     end
                  end
                  rqr_pkg::ACT_DEQ: begin
                     wrap_offset = IDX_W'(1);
                     if (count_ff != '0) begin
                        // read the head now, answer when the data lands
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = head_ff;
                        head_in     = wrap_index;
                        count_in    = count_m1;
                        state_in    = ST_DEQ_DATA;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  rqr_pkg::ACT_REV: begin
                     if (count_ff > CNT_W'(1)) begin
                        lo_in    = '0;
                        hi_in    = count_m1[IDX_W-1:0];
                        state_in = ST_REV_RD_LO;
                     end else begin
                        rsp_load  = 1'b1;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  default: begin
                     // unused code: answer with a failure, no state change
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_DEQ_DATA: begin
            rsp_load   = 1'b1;
            rsp_ok_in  = 1'b1;
            rsp_pop_in = rd_data_ff;
            state_in   = ST_IDLE;
         end
         ST_REV_RD_LO: begin
            wrap_offset = lo_ff;
            mem_rd_en   = 1'b1;
            mem_rd_addr = wrap_index;
            addr_lo_in  = wrap_index;
            state_in    = ST_REV_RD_HI;
         end
         ST_REV_RD_HI: begin
            wrap_offset = hi_ff;
            mem_rd_en   = 1'b1;
            mem_rd_addr = wrap_index;
            addr_hi_in  = wrap_index;
            hold_in     = rd_data_ff;
            state_in    = ST_REV_WR_LO;
         end
         ST_REV_WR_LO: begin
            // high word goes to the low slot
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_lo_ff;
            mem_wr_data = rd_data_ff;
            state_in    = ST_REV_WR_HI;
         end
         ST_REV_WR_HI: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr_hi_ff;
            mem_wr_data = hold_ff;
            lo_in       = lo_ff + IDX_W'(1);
            hi_in       = hi_ff - IDX_W'(1);
            // another swap while lo + 1 < hi - 1
            if (lo_plus2 < {1'b0, hi_ff}) begin
               state_in = ST_REV_RD_LO;
            end else begin
               rsp_load  = 1'b1;
               rsp_ok_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // occupancy flags always report the state after the request
      fill_ext     = {{FILL_W{1'b0}}, count_in};
      rsp_empty_in = (count_in == '0);
      rsp_full_in  = (count_in == CNT_FULL);
      rsp_fill_in  = fill_ext[FILL_W-1:0];

      // output register: filled on completion, emptied by a response transfer
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_lo_ff <= addr_lo_in;
      addr_hi_ff <= addr_hi_in;
      hold_ff    <= hold_in;
      if (rsp_load) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_pop_ff   <= rsp_pop_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_full_ff  <= rsp_full_in;
         rsp_fill_ff  <= rsp_fill_in;
      end
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         slots[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= slots[mem_rd_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_pop_value  = rsp_pop_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_is_full    = rsp_full_ff;
   assign rsp_fill_count = rsp_fill_ff;

   // occupancy never goes past capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count above capacity");

   // swap pointers stay ordered while reversing
   a_rev_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REV_RD_LO || state_ff == ST_REV_RD_HI ||
       state_ff == ST_REV_WR_LO || state_ff == ST_REV_WR_HI) |-> (lo_ff < hi_ff))
      else $error("reverse pointers crossed");

   // enqueue into a full queue fails and leaves the count alone
   a_enq_full: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action == rqr_pkg::ACT_ENQ && count_ff == CNT_FULL)
      |=> (rsp_valid_ff && !rsp_ok_ff && $stable(count_ff)))
      else $error("enqueue on full queue not rejected");

   // a response never claims empty and full at once
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_empty_ff && rsp_full_ff))
      else $error("empty and full both set");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench for the ring queue with in-place reverse: directed table, then random traffic
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W   = rqr_pkg::DATA_W;
   localparam int ACTION_W = rqr_pkg::ACTION_W;
   localparam int FILL_W   = rqr_pkg::FILL_W;

   localparam int QDEPTH = rqr_pkg::DEPTH_DEFAULT;
   // the fourth request code is unused by the block and must be ignored
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   // requests sent over the whole run, directed rows included
   localparam int TOTAL_ITEMS = 400;
   // cycles with no transfer on either channel before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // settle time after the last response: longer than a full-depth reverse
   localparam int TAIL_CYCLES = 40;

   // one response, field for field
   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] pop;
      logic                     empty;
      logic                     full;
      logic [FILL_W-1:0]        fill;
   } rsp_type;

   // one row of the directed table; fixed_rsp marks a hand-written expectation
   typedef struct {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] value;
      bit                       fixed_rsp;
      rsp_type                  rsp;
   } stim_row_type;

   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_ready;
   logic [ACTION_W-1:0]      req_action     = '0;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready      = 1'b0;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_pop_value;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic [FILL_W-1:0]        rsp_fill_count;

   ring_queue_with_reverse_core #(.DEPTH(QDEPTH)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_fill_count (rsp_fill_count)
   );

   // shadow copy of the queue contents and pointers
   logic signed [DATA_W-1:0] q_slots [QDEPTH];
   int q_head  = 0;
   int q_count = 0;

   rsp_type      pending_rsp [$];   // responses still owed by the block, oldest first
   stim_row_type dir_rows    [$];

   int  errors       = 0;
   int  n_req        = 0;
   int  n_rsp        = 0;
   int  n_full_rej   = 0;
   int  n_empty_rej  = 0;
   int  n_rev        = 0;
   int  n_deep_rev   = 0;
   int  idle_cycles  = 0;
   bit  steady       = 1'b0; // both sides run without idling while set

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // queue behavior: applies one request to the shadow state, returns the
   // response it must produce
   // ---------------------------------------------------------------------
   function automatic rsp_type queue_predict(logic [ACTION_W-1:0] act,
                                             logic signed [DATA_W-1:0] val);
      rsp_type r;
      int lo;
      int hi;
      int a;
      int b;
      logic signed [DATA_W-1:0] t;
      r = '0;
      case (act)
         rqr_pkg::ACT_ENQ: begin
            if (q_count < QDEPTH) begin
               q_slots[(q_head + q_count) % QDEPTH] = val;
               q_count++;
               r.ok = 1'b1;
            end else begin
               n_full_rej++;
            end
         end
         rqr_pkg::ACT_DEQ: begin
            if (q_count != 0) begin
               r.pop   = q_slots[q_head];
               q_head  = (q_head + 1) % QDEPTH;
               q_count--;
               r.ok    = 1'b1;
            end else begin
               n_empty_rej++;
            end
         end
         rqr_pkg::ACT_REV: begin
            // swap mirrored entries around the middle of the stored run
            lo = 0;
            hi = q_count - 1;
            while (lo < hi) begin
               a = (q_head + lo) % QDEPTH;
               b = (q_head + hi) % QDEPTH;
               t = q_slots[a];
               q_slots[a] = q_slots[b];
               q_slots[b] = t;
               lo++;
               hi--;
            end
            r.ok = 1'b1;
            n_rev++;
            if (q_count >= QDEPTH - 1) n_deep_rev++;
         end
         default: ;   // unused code: no state change, ok stays low
      endcase
      r.empty = (q_count == 0);
      r.full  = (q_count == QDEPTH);
      r.fill  = q_count[FILL_W-1:0];
      return r;
   endfunction

   function automatic stim_row_type make_row(logic [ACTION_W-1:0] act,
                                             logic signed [DATA_W-1:0] val, bit fixed,
                                             logic ok, logic signed [DATA_W-1:0] pop,
                                             logic empty, logic full,
                                             logic [FILL_W-1:0] fill);
      stim_row_type row;
      row.action    = act;
      row.value     = val;
      row.fixed_rsp = fixed;
      row.rsp.ok    = ok;
      row.rsp.pop   = pop;
      row.rsp.empty = empty;
      row.rsp.full  = full;
      row.rsp.fill  = fill;
      return row;
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // random word with the extremes mixed in now and then
   function automatic logic signed [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 11))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh0000_0000;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   task automatic idle_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // offer one request, hold it until the transfer, then record what the
   // block owes for it; valid is left high so back-to-back requests do not
   // drop it between transfers
   task automatic send_item(logic [ACTION_W-1:0] act, logic signed [DATA_W-1:0] val,
                            bit fixed, rsp_type fixed_val);
      rsp_type predicted;
      int g;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_push_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = queue_predict(act, val);
      pending_rsp.push_back(fixed ? fixed_val : predicted);
      n_req++;
      g = steady ? 0 : pick_gap();
      if (g > 0) idle_sender(g);
   endtask

   task automatic rand_item(logic [ACTION_W-1:0] act);
      send_item(act, rand_word(), 1'b0, '0);
   endtask

   // hold off new requests until every owed response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // response side: random backpressure, with free-running stretches
   // ---------------------------------------------------------------------
   int ready_hold = 0;
   always @(posedge clock) begin
      if (steady) begin
         rsp_ready  <= 1'b1;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else if (rsp_ready) begin
         ready_hold = pick_gap();
         if (ready_hold == 0) begin
            ready_hold = $urandom_range(1, 8);   // keep accepting a while
         end else begin
            rsp_ready <= 1'b0;
         end
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold = $urandom_range(1, 12);
      end
   end

   task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endtask

   // every response transfer is matched with the oldest owed response
   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response transfer with nothing outstanding", $time);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("ok",         DATA_W'(want.ok),    DATA_W'(rsp_ok));
            check_field("pop_value",  want.pop,            rsp_pop_value);
            check_field("is_empty",   DATA_W'(want.empty), DATA_W'(rsp_is_empty));
            check_field("is_full",    DATA_W'(want.full),  DATA_W'(rsp_is_full));
            check_field("fill_count", DATA_W'(want.fill),  DATA_W'(rsp_fill_count));
         end
      end
   end

   // watchdog: too long without any transfer means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d responses owed",
                  $time, idle_cycles, pending_rsp.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int n;
      int pick;
      bit paused;
      paused = 1'b0;
      foreach (q_slots[i]) q_slots[i] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table: empty-queue errors, unused code, single-entry reverse,
      // extreme words, fill to full, overflow, full reverse
      dir_rows.push_back(make_row(rqr_pkg::ACT_DEQ, 32'sh0000_0000, 1, 0, 0, 1, 0, 0));
      dir_rows.push_back(make_row(rqr_pkg::ACT_REV, -32'sd1,        1, 1, 0, 1, 0, 0));
      dir_rows.push_back(make_row(ACT_UNUSED,       32'sh7FFF_FFFF, 1, 0, 0, 1, 0, 0));
      dir_rows.push_back(make_row(rqr_pkg::ACT_ENQ, 32'sh7FFF_FFFF, 1, 1, 0, 0, 0, 1));
      dir_rows.push_back(make_row(rqr_pkg::ACT_REV, 32'sh0000_0000, 1, 1, 0, 0, 0, 1));
      dir_rows.push_back(make_row(rqr_pkg::ACT_DEQ, -32'sd1,        1, 1, 32'sh7FFF_FFFF,
                                  1, 0, 0));
      dir_rows.push_back(make_row(rqr_pkg::ACT_ENQ, 32'sh8000_0000, 1, 1, 0, 0, 0, 1));
      // repeated-nibble words up to all ones, filling the queue
      for (int i = 1; i < QDEPTH; i++) begin
         dir_rows.push_back(make_row(rqr_pkg::ACT_ENQ, 32'h1111_1111 * i,
                                     0, 0, 0, 0, 0, 0));
      end
      dir_rows.push_back(make_row(rqr_pkg::ACT_ENQ, 32'sh0000_0000, 1, 0, 0, 0, 1,
                                  FILL_W'(QDEPTH)));
      dir_rows.push_back(make_row(rqr_pkg::ACT_REV, 32'sh5555_5555, 1, 1, 0, 0, 1,
                                  FILL_W'(QDEPTH)));
      dir_rows.push_back(make_row(rqr_pkg::ACT_DEQ, 32'shAAAA_AAAA, 0, 0, 0, 0, 0, 0));
      dir_rows.push_back(make_row(ACT_UNUSED,       -32'sd1,        1, 0, 0, 0, 0,
                                  FILL_W'(QDEPTH - 1)));

      foreach (dir_rows[i]) begin
         send_item(dir_rows[i].action, dir_rows[i].value, dir_rows[i].fixed_rsp,
                   dir_rows[i].rsp);
      end

      // random part: mostly fill and drain runs around reverses, some noise;
      // the first stretch runs with no idling on either side
      steady = 1'b1;
      while (n_req < TOTAL_ITEMS) begin
         if (n_req >= 60) steady = 1'b0;
         if (!paused && n_req >= TOTAL_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            // fill run, sometimes to full and past it
            n = (pick == 0) ? QDEPTH - q_count + $urandom_range(0, 2)
                            : $urandom_range(1, QDEPTH - q_count + 1);
            repeat (n) rand_item(rqr_pkg::ACT_ENQ);
         end else if (pick < 5) begin
            // drain run, sometimes to empty and past it
            n = (pick == 3) ? q_count + $urandom_range(0, 1)
                            : $urandom_range(1, q_count + 1);
            repeat (n) rand_item(rqr_pkg::ACT_DEQ);
         end else if (pick < 7) begin
            // reverse, then read the whole order back out now and then
            rand_item(rqr_pkg::ACT_REV);
            if (pick == 5) begin
               n = q_count;
               repeat (n) rand_item(rqr_pkg::ACT_DEQ);
            end
         end else begin
            // noise: any code, the unused one included
            n = $urandom_range(1, 6);
            repeat (n) rand_item(logic'($urandom_range(0, 3)) ? ACTION_W'($urandom_range(0, 3))
                                                             : ACT_UNUSED);
         end
      end

      idle_sender(1);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d responses: %0d reverses (%0d near full),",
               n_req, n_rsp, n_rev, n_deep_rev);
      $display("%0d enqueues refused when full, %0d dequeues refused when empty",
               n_full_rej, n_empty_rej);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rqr_pkg.sv
rtl/rqr_wrap.sv
rtl/ring_queue_with_reverse_core.sv
test/tb.sv
